>>> src/hwr_pkg.sv
// shared types, codes and constants for the hash table weighted replace unit
// no dependencies
package hwr_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int KEY_W          = 64;
  localparam int DEPTH_W        = 7;
  localparam int BOUND_W        = 2;
  localparam int PAYLOAD_W      = 40;
  localparam int EPOCH_W        = 8;
  localparam int WEIGHT_W       = 11;
  localparam int IN_DATA_W      = 120;
  localparam int OUT_DATA_W     = 64;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;

  // packed so that the valid flag sits in bit 0
  typedef struct packed {
    logic [EPOCH_W-1:0]   epoch;
    logic [PAYLOAD_W-1:0] payload;
    logic                 pv;
    logic                 has_move;
    logic [BOUND_W-1:0]   bound;
    logic [DEPTH_W-1:0]   depth;
    logic                 valid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam int SLOT_W  = KEY_W + ENTRY_W;

  typedef struct packed {
    logic [KEY_W-1:0] tag;
    entry_t           entry;
  } slot_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic done;
    logic clr_we;
  } ctl_t;

endpackage

>>> src/hwr_mem.sv
// table memory with separate read and write ports, registered read, one write per cycle
// depends on hwr_pkg
module hwr_mem #(
  parameter int ADDR_BITS = hwr_pkg::INDEX_BITS_DEF,
  parameter int DATA_BITS = hwr_pkg::SLOT_W
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
  logic [DATA_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/hwr_replace.sv
// replacement decision: compares weights (depth, age, bound, move and pv flags) of stored and new entry
// depends on hwr_pkg
module hwr_replace (
  input  hwr_pkg::entry_t               old_entry,
  input  hwr_pkg::entry_t               new_entry,
  input  logic [hwr_pkg::EPOCH_W-1:0]   epoch,
  output logic                          win
);

  function automatic logic signed [hwr_pkg::WEIGHT_W-1:0] weight(
    input hwr_pkg::entry_t              e,
    input logic [hwr_pkg::EPOCH_W-1:0]  ep
  );
    logic [hwr_pkg::EPOCH_W-1:0]          age;
    logic signed [hwr_pkg::WEIGHT_W-1:0]  w;
    age = ep - e.epoch;
    w = $signed({2'b00, e.depth, 2'b00}) - $signed({3'b000, age});
    if (e.bound == hwr_pkg::BOUND_EXACT) begin
      w = w + 11'sd6;
    end
    if (!e.has_move) begin
      w = w - 11'sd4;
    end
    if (e.pv) begin
      w = w + 11'sd2;
    end
    return w;
  endfunction

  logic signed [hwr_pkg::WEIGHT_W-1:0] w_old;
  logic signed [hwr_pkg::WEIGHT_W-1:0] w_new;

  always_comb begin
    w_old = weight(old_entry, epoch);
    w_new = weight(new_entry, epoch);
    // invalid entries carry the minimum weight
    win = !old_entry.valid || (new_entry.valid && (w_new >= w_old));
  end

endmodule

>>> src/hwr_ctrl.sv
// sequencer: clearing pass after reset, accept, lookup and write back
// depends on hwr_pkg
module hwr_ctrl #(
  parameter int INDEX_BITS = hwr_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_free,
  output hwr_pkg::ctl_t         ctl,
  output logic [INDEX_BITS-1:0] clr_addr
);

  hwr_pkg::state_t       state_r, state_nxt;
  logic [INDEX_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                  clr_last;

  assign clr_last = (clr_cnt_r == {INDEX_BITS{1'b1}});
  assign clr_addr = clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hwr_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      hwr_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          state_nxt = hwr_pkg::ST_IDLE;
        end
      end
      hwr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = hwr_pkg::ST_LOOKUP;
        end
      end
      hwr_pkg::ST_LOOKUP: begin
        if (out_free) begin
          state_nxt = hwr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hwr_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      hwr_pkg::ST_CLEAR: begin
        ctl.clr_we = 1'b1;
      end
      hwr_pkg::ST_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.rd_en    = in_valid;
      end
      hwr_pkg::ST_LOOKUP: begin
        ctl.done = out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

>>> src/hash_table_weighted_replace_unit.sv
// result: request and table word are registered on the input transfer, the output register
// is loaded in the lookup state once the output is free; one item at a time, a new input is
// taken only back in idle, after the read and write back through the two port table memory
// reset: a clearing pass writes every slot to zero, in_tready low meanwhile;
// current epoch resets to zero
module hash_table_weighted_replace_unit #(
  parameter int INDEX_BITS = hwr_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // key, valid_req, search_depth, bound_kind, has_move, is_pv, payload, zero pad
  input  logic [hwr_pkg::IN_DATA_W-1:0]     in_tdata,
  // func
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // hit_valid, out_depth, out_bound, out_has_move, out_pv, out_payload,
  // out_epoch, written, zero pad
  output logic [hwr_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hwr_pkg::EPOCH_W-1:0]       cfg_data
);

  localparam int KW = hwr_pkg::KEY_W;

  hwr_pkg::ctl_t                  ctl;
  logic [INDEX_BITS-1:0]          clr_addr;
  logic                           out_free;
  logic [hwr_pkg::EPOCH_W-1:0]    epoch_r;

  logic                           func_r;
  logic [KW-1:0]                  key_r;
  hwr_pkg::entry_t                req_r;
  hwr_pkg::entry_t                req_nxt;
  hwr_pkg::entry_t                new_entry;

  logic [hwr_pkg::SLOT_W-1:0]     rd_word;
  hwr_pkg::slot_t                 old_slot;
  hwr_pkg::slot_t                 wr_slot;
  logic                           win;

  logic                           wr_en;
  logic [INDEX_BITS-1:0]          wr_addr;

  logic                           out_valid_r, out_valid_nxt;
  logic [hwr_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = ctl.in_ready;

  hwr_ctrl #(.INDEX_BITS(INDEX_BITS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .ctl      (ctl),
    .clr_addr (clr_addr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= '0;
    end else if (cfg_valid) begin
      epoch_r <= cfg_data;
    end
  end

  // request capture on the input transfer
  always_comb begin
    req_nxt          = '0;
    req_nxt.valid    = in_tdata[64];
    req_nxt.depth    = in_tdata[71:65];
    req_nxt.bound    = in_tdata[73:72];
    req_nxt.has_move = in_tdata[74];
    req_nxt.pv       = in_tdata[75];
    req_nxt.payload  = in_tdata[115:76];
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      func_r <= in_tuser;
      key_r  <= in_tdata[KW-1:0];
      req_r  <= req_nxt;
    end
  end

  hwr_mem #(
    .ADDR_BITS (INDEX_BITS),
    .DATA_BITS (hwr_pkg::SLOT_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (ctl.rd_en),
    .rd_addr (in_tdata[INDEX_BITS-1:0]),
    .rd_data (rd_word),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot)
  );

  assign old_slot = rd_word;

  always_comb begin
    new_entry       = req_r;
    new_entry.epoch = epoch_r;
  end

  hwr_replace u_replace (
    .old_entry (old_slot.entry),
    .new_entry (new_entry),
    .epoch     (epoch_r),
    .win       (win)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = key_r[INDEX_BITS-1:0];
    wr_slot = '0;
    if (ctl.clr_we) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
    end else if (ctl.done && (func_r == hwr_pkg::FUNC_STORE) && win) begin
      wr_en         = 1'b1;
      wr_slot.tag   = key_r;
      wr_slot.entry = new_entry;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (func_r == hwr_pkg::FUNC_STORE) begin
      out_data_nxt[hwr_pkg::ENTRY_W] = win;
    end else if (old_slot.tag == key_r) begin
      out_data_nxt[hwr_pkg::ENTRY_W-1:0] = old_slot.entry;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// testbench for hash_table_weighted_replace_unit: directed and random loads and stores,
// checked against an in-bench model of the slot table and its replacement weight
// depends on hwr_pkg and the unit's rtl
module testbench;

  localparam int WATCHDOG_LIMIT = 300000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 150;
  localparam int IDX_W          = hwr_pkg::INDEX_BITS_DEF;
  localparam int HI_W           = hwr_pkg::KEY_W - hwr_pkg::INDEX_BITS_DEF;

  typedef struct packed {
    logic [3:0]                    pad;
    logic [hwr_pkg::PAYLOAD_W-1:0] payload;
    logic                          pv;
    logic                          has_move;
    logic [hwr_pkg::BOUND_W-1:0]   bound;
    logic [hwr_pkg::DEPTH_W-1:0]   depth;
    logic                          valid_req;
    logic [hwr_pkg::KEY_W-1:0]     key;
  } probe_req_t;

  typedef struct packed {
    logic [2:0]                    pad;
    logic                          written;
    logic [hwr_pkg::EPOCH_W-1:0]   epoch;
    logic [hwr_pkg::PAYLOAD_W-1:0] payload;
    logic                          pv;
    logic                          has_move;
    logic [hwr_pkg::BOUND_W-1:0]   bound;
    logic [hwr_pkg::DEPTH_W-1:0]   depth;
    logic                          hit_valid;
  } probe_res_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [hwr_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [hwr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [hwr_pkg::EPOCH_W-1:0]    cfg_data;

  logic [hwr_pkg::KEY_W-1:0]      tag_mem [logic [IDX_W-1:0]];
  hwr_pkg::entry_t                entry_mem [logic [IDX_W-1:0]];
  logic [hwr_pkg::EPOCH_W-1:0]    model_epoch;
  probe_res_t                     expected_q [$];
  int                             error_count;
  bit                             burst_mode;
  bit                             hold_req;
  logic [IDX_W-1:0]               idx_pool [8];
  logic [HI_W-1:0]                hi_pool [4];

  hash_table_weighted_replace_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int replace_weight(hwr_pkg::entry_t e);
    int w;
    logic [hwr_pkg::EPOCH_W-1:0] age;
    if (!e.valid) return -100000;
    age = model_epoch - e.epoch;
    w = 4 * int'(e.depth) - int'(age);
    if (e.bound == hwr_pkg::BOUND_EXACT) w += 6;
    if (!e.has_move) w -= 4;
    if (e.pv) w += 2;
    return w;
  endfunction

  function automatic probe_res_t table_access(logic func, probe_req_t r);
    probe_res_t res;
    logic [IDX_W-1:0] idx;
    logic [hwr_pkg::KEY_W-1:0] tag;
    hwr_pkg::entry_t old_e;
    hwr_pkg::entry_t new_e;
    res = '0;
    idx = r.key[IDX_W-1:0];
    tag = tag_mem.exists(idx) ? tag_mem[idx] : '0;
    old_e = entry_mem.exists(idx) ? entry_mem[idx] : '0;
    if (func == hwr_pkg::FUNC_LOAD) begin
      if (tag == r.key) begin
        res.hit_valid = old_e.valid;
        res.depth     = old_e.depth;
        res.bound     = old_e.bound;
        res.has_move  = old_e.has_move;
        res.pv        = old_e.pv;
        res.payload   = old_e.payload;
        res.epoch     = old_e.epoch;
      end
    end else begin
      new_e.valid    = r.valid_req;
      new_e.depth    = r.depth;
      new_e.bound    = r.bound;
      new_e.has_move = r.has_move;
      new_e.pv       = r.pv;
      new_e.payload  = r.payload;
      new_e.epoch    = model_epoch;
      if (replace_weight(old_e) <= replace_weight(new_e)) begin
        entry_mem[idx] = new_e;
        tag_mem[idx]   = r.key;
        res.written    = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic probe_req_t make_req(logic [hwr_pkg::KEY_W-1:0] key, logic vreq,
                                          logic [hwr_pkg::DEPTH_W-1:0] depth,
                                          logic [hwr_pkg::BOUND_W-1:0] bound,
                                          logic mv, logic pv,
                                          logic [hwr_pkg::PAYLOAD_W-1:0] payload);
    probe_req_t r;
    r = '0;
    r.key       = key;
    r.valid_req = vreq;
    r.depth     = depth;
    r.bound     = bound;
    r.has_move  = mv;
    r.pv        = pv;
    r.payload   = payload;
    return r;
  endfunction

  function automatic probe_req_t rand_req(bit hot);
    logic [hwr_pkg::KEY_W-1:0] key;
    logic [63:0] wide;
    logic [hwr_pkg::DEPTH_W-1:0] depth;
    if (hot) key = {hi_pool[$urandom_range(0, 3)], idx_pool[$urandom_range(0, 7)]};
    else key = {$urandom, $urandom};
    wide = {$urandom, $urandom};
    // keep depths close together now and then so ages and flags decide
    depth = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(20, 27));
    return make_req(key, $urandom_range(0, 9) != 0, depth, 2'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    wide[hwr_pkg::PAYLOAD_W-1:0]);
  endfunction

  task automatic send_op(input logic func, input probe_req_t r);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    in_tuser  <= func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(table_access(func, r));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_epoch(input logic [hwr_pkg::EPOCH_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_epoch = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_after_reset();
    send_op(hwr_pkg::FUNC_LOAD, make_req('0, 1'b0, '0, '0, 1'b0, 1'b0, '0));
    send_op(hwr_pkg::FUNC_LOAD, make_req('1, 1'b1, '1, '1, 1'b1, 1'b1, '1));
  endtask

  task automatic test_replacement_rules();
    logic [hwr_pkg::KEY_W-1:0] k1;
    logic [hwr_pkg::KEY_W-1:0] k1_alias;
    logic [hwr_pkg::KEY_W-1:0] k2;
    k1       = 64'hA5A5_0000_0000_1234;
    k1_alias = 64'h5A5A_FFFF_FFFF_1234;
    k2       = 64'h0123_4567_89AB_5555;
    write_epoch(8'd0);
    send_op(hwr_pkg::FUNC_STORE, make_req(k1, 1'b1, 7'd10, 2'd1, 1'b1, 1'b0, 40'h12_3456_789A));
    send_op(hwr_pkg::FUNC_LOAD, make_req(k1, 1'b0, '0, '0, 1'b0, 1'b0, '0));
    send_op(hwr_pkg::FUNC_LOAD, make_req(k1_alias, 1'b0, '0, '0, 1'b0, 1'b0, '0));
    // invalid entry against a valid one
    send_op(hwr_pkg::FUNC_STORE, make_req(k1_alias, 1'b0, 7'd127, 2'd0, 1'b1, 1'b1, '1));
    send_op(hwr_pkg::FUNC_STORE,
            make_req(k1_alias, 1'b1, 7'd9, 2'd0, 1'b1, 1'b1, 40'hFF_0000_00FF));
    send_op(hwr_pkg::FUNC_STORE, make_req(k1, 1'b1, 7'd0, 2'd2, 1'b0, 1'b0, '0));
    send_op(hwr_pkg::FUNC_LOAD, make_req(k1_alias, 1'b0, '0, '0, 1'b0, 1'b0, '0));
    // equal weight overwrites
    send_op(hwr_pkg::FUNC_STORE, make_req(k1, 1'b1, 7'd9, 2'd0, 1'b1, 1'b1, 40'h00_FFFF_FF00));
    send_op(hwr_pkg::FUNC_LOAD, make_req(k1, 1'b0, '0, '0, 1'b0, 1'b0, '0));
    send_op(hwr_pkg::FUNC_STORE, make_req('1, 1'b1, 7'd127, 2'd3, 1'b1, 1'b1, '1));
    send_op(hwr_pkg::FUNC_LOAD, make_req('1, 1'b0, '0, '0, 1'b0, 1'b0, '0));
    // invalid entry into an empty slot, then read back with hit_valid low
    send_op(hwr_pkg::FUNC_STORE, make_req(k2, 1'b0, 7'd55, 2'd2, 1'b1, 1'b1, 40'hAB_CDEF_0123));
    send_op(hwr_pkg::FUNC_LOAD, make_req(k2, 1'b0, '0, '0, 1'b0, 1'b0, '0));
    send_op(hwr_pkg::FUNC_STORE, make_req('0, 1'b1, 7'd0, 2'd3, 1'b0, 1'b0, '0));
    send_op(hwr_pkg::FUNC_LOAD, make_req('0, 1'b0, '0, '0, 1'b0, 1'b0, '0));
  endtask

  task automatic test_epoch_wrap();
    logic [hwr_pkg::KEY_W-1:0] k3;
    k3 = 64'hC3C3_1111_2222_7777;
    write_epoch(8'd255);
    send_op(hwr_pkg::FUNC_STORE, make_req(k3, 1'b1, 7'd20, 2'd0, 1'b1, 1'b1, 40'h55_5555_5555));
    send_op(hwr_pkg::FUNC_LOAD, make_req(k3, 1'b0, '0, '0, 1'b0, 1'b0, '0));
    // epoch wraps from 255 to 0, so the stored entry's age is 1
    write_epoch(8'd0);
    send_op(hwr_pkg::FUNC_STORE, make_req(k3, 1'b1, 7'd20, 2'd0, 1'b1, 1'b0, 40'hAA_AAAA_AAAA));
    send_op(hwr_pkg::FUNC_STORE, make_req(k3, 1'b1, 7'd21, 2'd0, 1'b1, 1'b0, 40'hAA_AAAA_AAAA));
    send_op(hwr_pkg::FUNC_LOAD, make_req(k3, 1'b0, '0, '0, 1'b0, 1'b0, '0));
  endtask

  task automatic test_random_phases();
    logic [hwr_pkg::EPOCH_W-1:0] epochs [6];
    bit hot;
    epochs = '{8'd1, 8'd128, 8'($urandom), 8'd254, 8'd255, 8'd3};
    foreach (epochs[p]) begin
      write_epoch(epochs[p]);
      burst_mode = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        hot = $urandom_range(0, 3) != 0;
        send_op(1'($urandom_range(0, 1)), rand_req(hot));
      end
      burst_mode = 1'b0;
    end
  endtask

  task automatic test_stall_pressure();
    drain_results();
    burst_mode = 1'b1;
    hold_req   = 1'b1;
    for (int i = 0; i < 24; i++) send_op(1'($urandom_range(0, 1)), rand_req(1'b1));
    burst_mode = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  initial begin : result_checker
    int stall;
    probe_res_t got;
    probe_res_t want;
    out_tready <= 1'b0;
    stall = $urandom_range(0, 15);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected, expected none, actual %0h",
                   $time, out_tdata);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("hit_valid", 64'(want.hit_valid), 64'(got.hit_valid));
          compare_field("out_depth", 64'(want.depth), 64'(got.depth));
          compare_field("out_bound", 64'(want.bound), 64'(got.bound));
          compare_field("out_has_move", 64'(want.has_move), 64'(got.has_move));
          compare_field("out_pv", 64'(want.pv), 64'(got.pv));
          compare_field("out_payload", 64'(want.payload), 64'(got.payload));
          compare_field("out_epoch", 64'(want.epoch), 64'(got.epoch));
          compare_field("written", 64'(want.written), 64'(got.written));
          compare_field("pad", 64'(want.pad), 64'(got.pad));
        end
        stall = burst_mode ? 0 : $urandom_range(0, 15);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = hwr_pkg::FUNC_LOAD;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    model_epoch = '0;
    error_count = 0;
    burst_mode  = 1'b0;
    hold_req    = 1'b0;
    idx_pool[0] = '0;
    idx_pool[1] = '1;
    for (int i = 2; i < 8; i++) idx_pool[i] = IDX_W'($urandom);
    hi_pool[0] = '0;
    hi_pool[1] = '1;
    hi_pool[2] = HI_W'({$urandom, $urandom});
    hi_pool[3] = HI_W'({$urandom, $urandom});
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_replacement_rules();
    test_epoch_wrap();
    test_random_phases();
    test_stall_pressure();

    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/hwr_pkg.sv
src/hwr_mem.sv
src/hwr_replace.sv
src/hwr_ctrl.sv
src/hash_table_weighted_replace_unit.sv
tb/testbench.sv
